// ===== design/keypad_countdown_timer_controller_core_defines.svh =====
// assertion macros for the keypad countdown timer controller
// used by the top level; no other dependencies
`ifndef KEYPAD_COUNTDOWN_TIMER_CONTROLLER_CORE_DEFINES_SVH
`define KEYPAD_COUNTDOWN_TIMER_CONTROLLER_CORE_DEFINES_SVH

// condition in one cycle implies consequence in the same cycle
`define KCTC_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("kctc same-cycle check failed");

// condition in one cycle implies consequence in the next cycle
`define KCTC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("kctc next-cycle check failed");

`endif

// ===== design/kctc_pkg.sv =====
// shared types and constants for the keypad countdown timer controller
// no dependencies; used by the step logic and the top level
package kctc_pkg;

   // operating modes
   typedef enum logic [2:0] {
      MODE_ENTRY   = 3'd0,
      MODE_READY   = 3'd1,
      MODE_RUNNING = 3'd2,
      MODE_PAUSED  = 3'd3,
      MODE_HELD    = 3'd4
   } mode_type;

   // result event codes
   typedef enum logic [2:0] {
      EV_NONE      = 3'd0,
      EV_INVALID   = 3'd1,
      EV_FINISHED  = 3'd2,
      EV_DOOR_OPEN = 3'd3,
      EV_CANCELLED = 3'd4
   } event_type;

   // key codes
   localparam logic [3:0] KEY_DIGIT_MAX = 4'd9;
   localparam logic [3:0] KEY_START     = 4'd10;
   localparam logic [3:0] KEY_CLEAR     = 4'd11;

   // time and key-entry limits
   localparam logic [6:0] LIMIT_MMSS   = 7'd59;
   localparam logic [1:0] LAST_PRESS   = 2'd3;

   // action codes
   localparam logic ACTION_KEY  = 1'b0;
   localparam logic ACTION_TICK = 1'b1;

   // controller state
   typedef struct packed {
      mode_type         mode;
      logic [3:0][3:0]  digits;    // [0] is the newest digit
      logic [1:0]       presses;
      logic [6:0]       minutes;
      logic [6:0]       seconds;
   } state_type;

   // one result beat
   typedef struct packed {
      logic [2:0] mode;
      logic [6:0] minutes_shown;
      logic [6:0] seconds_shown;
      logic       beep;
      logic [2:0] event_res;
   } result_type;

   // tens digit times ten plus units digit
   function automatic logic [6:0] digit_pair(input logic [3:0] hi, input logic [3:0] lo);
      digit_pair = {hi, 3'b000} + {2'b00, hi, 1'b0} + {3'b000, lo};
   endfunction

endpackage

// ===== design/kctc_if.sv =====
// valid/ready channel interfaces for the request and response beats
// depends on nothing but plain logic types
interface kctc_req_if;
   logic       valid;
   logic       ready;
   logic       action;
   logic [3:0] key_code;
   logic       door_closed;

   modport source (output valid, output action, output key_code, output door_closed,
                   input ready);
   modport sink   (input valid, input action, input key_code, input door_closed,
                   output ready);
endinterface

interface kctc_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] mode;
   logic [6:0] minutes_shown;
   logic [6:0] seconds_shown;
   logic       beep;
   logic [2:0] event_res;

   modport source (output valid, output mode, output minutes_shown, output seconds_shown,
                   output beep, output event_res, input ready);
   modport sink   (input valid, input mode, input minutes_shown, input seconds_shown,
                   input beep, input event_res, output ready);
endinterface

// ===== design/kctc_step.sv =====
// next-state and result logic for one request beat
// depends on kctc_pkg
module kctc_step (
   input  kctc_pkg::state_type  cur_state,
   input  logic                 action,
   input  logic [3:0]           key_code,
   input  logic                 door_closed,
   output kctc_pkg::state_type  nxt_state,
   output kctc_pkg::result_type result
);

   logic                is_key;
   logic                start_key;
   logic                clear_key;
   logic                go_entry;
   logic                beep;
   kctc_pkg::event_type ev;

   // decode the beat
   assign is_key    = (action == kctc_pkg::ACTION_KEY);
   assign start_key = is_key && (key_code == kctc_pkg::KEY_START);
   assign clear_key = is_key && (key_code == kctc_pkg::KEY_CLEAR);

   // mode transitions and countdown
   always_comb begin
      nxt_state = cur_state;
      beep      = 1'b0;
      ev        = kctc_pkg::EV_NONE;
      go_entry  = 1'b0;
      case (cur_state.mode)
         kctc_pkg::MODE_READY: begin
            if (start_key) begin
               if (!door_closed) begin
                  beep = 1'b1;
                  ev   = kctc_pkg::EV_DOOR_OPEN;
               end else if (cur_state.minutes <= kctc_pkg::LIMIT_MMSS &&
                            cur_state.seconds <= kctc_pkg::LIMIT_MMSS) begin
                  nxt_state.mode = kctc_pkg::MODE_RUNNING;
               end else begin
                  beep     = 1'b1;
                  ev       = kctc_pkg::EV_INVALID;
                  go_entry = 1'b1;
               end
            end else if (clear_key) begin
               go_entry = 1'b1;
            end
         end
         kctc_pkg::MODE_RUNNING: begin
            if (!is_key) begin
               if (!door_closed) begin
                  nxt_state.mode = kctc_pkg::MODE_HELD;
                  beep           = 1'b1;
                  ev             = kctc_pkg::EV_DOOR_OPEN;
               end else begin
                  // decrement with borrow from minutes
                  if (cur_state.seconds == 7'd0) begin
                     if (cur_state.minutes != 7'd0) begin
                        nxt_state.minutes = cur_state.minutes - 7'd1;
                        nxt_state.seconds = kctc_pkg::LIMIT_MMSS;
                     end
                  end else begin
                     nxt_state.seconds = cur_state.seconds - 7'd1;
                  end
                  if (nxt_state.minutes == 7'd0 && nxt_state.seconds == 7'd0) begin
                     ev       = kctc_pkg::EV_FINISHED;
                     go_entry = 1'b1;
                  end
               end
            end else if (start_key) begin
               nxt_state.mode = kctc_pkg::MODE_PAUSED;
            end
         end
         kctc_pkg::MODE_PAUSED: begin
            if (start_key) begin
               nxt_state.mode = kctc_pkg::MODE_RUNNING;
            end else if (clear_key) begin
               ev       = kctc_pkg::EV_CANCELLED;
               go_entry = 1'b1;
            end
         end
         kctc_pkg::MODE_HELD: begin
            if (start_key) begin
               if (door_closed) begin
                  nxt_state.mode = kctc_pkg::MODE_RUNNING;
               end else begin
                  beep = 1'b1;
                  ev   = kctc_pkg::EV_DOOR_OPEN;
               end
            end
         end
         default: begin
            // entry mode, and any stray code behaves as entry
            nxt_state.mode = kctc_pkg::MODE_ENTRY;
            if (is_key) begin
               if (key_code <= kctc_pkg::KEY_DIGIT_MAX) begin
                  nxt_state.digits = {cur_state.digits[2:0], key_code};
               end
               if (cur_state.presses == kctc_pkg::LAST_PRESS) begin
                  nxt_state.minutes = kctc_pkg::digit_pair(nxt_state.digits[3],
                                                           nxt_state.digits[2]);
                  nxt_state.seconds = kctc_pkg::digit_pair(nxt_state.digits[1],
                                                           nxt_state.digits[0]);
                  nxt_state.presses = 2'd0;
                  nxt_state.mode    = kctc_pkg::MODE_READY;
               end else begin
                  nxt_state.presses = cur_state.presses + 2'd1;
               end
            end
         end
      endcase
      // back to entry clears the keyed digits
      if (go_entry) begin
         nxt_state.mode    = kctc_pkg::MODE_ENTRY;
         nxt_state.digits  = '0;
         nxt_state.presses = 2'd0;
      end
   end

   // result beat
   always_comb begin
      result.mode      = nxt_state.mode;
      result.beep      = beep;
      result.event_res = ev;
      if (nxt_state.mode == kctc_pkg::MODE_ENTRY) begin
         result.minutes_shown = kctc_pkg::digit_pair(nxt_state.digits[3], nxt_state.digits[2]);
         result.seconds_shown = kctc_pkg::digit_pair(nxt_state.digits[1], nxt_state.digits[0]);
      end else begin
         result.minutes_shown = nxt_state.minutes;
         result.seconds_shown = nxt_state.seconds;
      end
   end

endmodule

// ===== design/keypad_countdown_timer_controller_core.sv =====
// Keypad countdown timer controller: each request beat (a key press or a one-second
// tick, with the sampled door level) yields exactly one response beat carrying the new
// mode, the mm:ss shown, the beep flag and an event code. The block takes one beat per
// clock while the output register is empty or being drained: the controller state
// updates on the accepting edge and the response lands in a single output register,
// valid in the cycle after acceptance. No clearing pass after reset.
// Depends on kctc_pkg, kctc_if, kctc_step and the assertion macro header.
`include "keypad_countdown_timer_controller_core_defines.svh"

module keypad_countdown_timer_controller_core (
   input  logic           clock,
   input  logic           reset,
   kctc_req_if.sink       req_bus,
   kctc_rsp_if.source     rsp_bus
);

   kctc_pkg::state_type  state_ff;
   kctc_pkg::state_type  state_in;
   kctc_pkg::result_type rsp_ff;
   kctc_pkg::result_type rsp_in;
   logic                 rsp_valid_ff;
   logic                 req_ready;
   logic                 req_accept;

   // take a beat whenever the output register can be refilled
   assign req_ready     = !rsp_valid_ff || rsp_bus.ready;
   assign req_accept    = req_bus.valid && req_ready;
   assign req_bus.ready = req_ready;

   // next state and response for the offered beat
   kctc_step u_step (
      .cur_state   (state_ff),
      .action      (req_bus.action),
      .key_code    (req_bus.key_code),
      .door_closed (req_bus.door_closed),
      .nxt_state   (state_in),
      .result      (rsp_in)
   );

   // controller state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.mode    <= kctc_pkg::MODE_ENTRY;
         state_ff.digits  <= '0;
         state_ff.presses <= 2'd0;
         state_ff.minutes <= 7'd0;
         state_ff.seconds <= 7'd0;
      end else if (req_accept) begin
         state_ff <= state_in;
      end
   end

   // response valid flag
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // response payload
   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.mode          = rsp_ff.mode;
   assign rsp_bus.minutes_shown = rsp_ff.minutes_shown;
   assign rsp_bus.seconds_shown = rsp_ff.seconds_shown;
   assign rsp_bus.beep          = rsp_ff.beep;
   assign rsp_bus.event_res     = rsp_ff.event_res;

   // checks
   `KCTC_ASSERT_SAME(a_beep_event, clock, reset, rsp_valid_ff && rsp_ff.beep, rsp_ff.event_res == kctc_pkg::EV_DOOR_OPEN || rsp_ff.event_res == kctc_pkg::EV_INVALID)
   `KCTC_ASSERT_SAME(a_presses_entry, clock, reset, state_ff.mode != kctc_pkg::MODE_ENTRY, state_ff.presses == 2'd0)
   `KCTC_ASSERT_NEXT(a_accept_rsp, clock, reset, req_accept, rsp_valid_ff)
   `KCTC_ASSERT_SAME(a_run_range, clock, reset, state_ff.mode == kctc_pkg::MODE_RUNNING, state_ff.minutes <= kctc_pkg::LIMIT_MMSS && state_ff.seconds <= kctc_pkg::LIMIT_MMSS)

endmodule
